// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define STS_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("sts assertion failed");

`define STS_ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("sts forbidden condition seen");

`else

`define STS_ASSERT(label, clk, rst_n, prop)
`define STS_ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

// ===== rtl/core/sts_pkg.sv =====
package sts_pkg;

    localparam int OP_W    = 2;
    localparam int VALUE_W = 16;
    localparam int FIRST_W = 4;
    localparam int PROBE_W = 3;

    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    typedef logic signed [VALUE_W-1:0] value_t;

    typedef struct packed {
        logic eq;
        logic key_lt;
    } cmp_t;

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_INS_RD   = 7'b0000010,
        S_INS_CMP  = 7'b0000100,
        S_SRCH_RD  = 7'b0001000,
        S_SRCH_CMP = 7'b0010000,
        S_SCAN_RD  = 7'b0100000,
        S_SCAN_CMP = 7'b1000000
    } state_t;

endpackage

// ===== rtl/core/sts_in_if.sv =====
interface sts_in_if;

    logic                              valid;
    logic                              ready;
    logic [sts_pkg::OP_W-1:0]          operation;
    logic signed [sts_pkg::VALUE_W-1:0] value;

    modport source (output valid, output operation, output value, input ready);
    modport sink (input valid, input operation, input value, output ready);

endinterface

// ===== rtl/core/sts_out_if.sv =====
interface sts_out_if;

    logic                          valid;
    logic                          ready;
    logic                          found;
    logic [sts_pkg::FIRST_W-1:0]   first_index;
    logic [sts_pkg::PROBE_W-1:0]   probe_count;
    logic                          load_dropped;

    modport source (
        output valid, output found, output first_index, output probe_count,
        output load_dropped, input ready
    );
    modport sink (
        input valid, input found, input first_index, input probe_count,
        input load_dropped, output ready
    );

endinterface

// ===== rtl/core/sts_cmp.sv =====
module sts_cmp (
    input  sts_pkg::value_t key,
    input  sts_pkg::value_t entry,
    output sts_pkg::cmp_t   result
);
    import sts_pkg::*;

    // shared signed comparator for insert, search and scan
    assign result.eq     = (key == entry);
    assign result.key_lt = (key < entry);

endmodule

// ===== rtl/core/sorted_table_search_unit.sv =====
// Sorted table search unit: keeps up to TABLE_SIZE signed 16-bit values in ascending
// order in a single-port-read table memory and answers one item at a time. A load
// inserts its value after any equal entries, shifting larger entries up one place at
// a time; a load into a full table, a clear and the unused code are answered straight
// from idle. A query runs a binary search and, on a hit, a linear scan from the bottom
// of the table for the first equal entry. Every step is paced by the one registered
// read port of the table and the one shared comparator. The table contents are not
// cleared at reset; only the entry count is. The next item is taken once the unit is
// back in idle and its result register is free or being emptied.
`include "assert_macros.svh"

module sorted_table_search_unit #(
    parameter int TABLE_SIZE = 16
) (
    input  logic clk,
    input  logic rst_n,
    sts_in_if.sink    req,
    sts_out_if.source rsp
);
    import sts_pkg::*;

    localparam int CNT_W = $clog2(TABLE_SIZE + 1);
    localparam int IDX_W = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam logic [CNT_W-1:0] FULL = CNT_W'(TABLE_SIZE);

    value_t table_mem [TABLE_SIZE];

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               ovalid_reg, ovalid_next;

    value_t             key_reg, key_next;
    logic [IDX_W-1:0]   pos_reg, pos_next;
    logic [CNT_W-1:0]   lo_reg, lo_next;
    logic [CNT_W-1:0]   hi1_reg, hi1_next;
    logic [IDX_W-1:0]   mid_reg, mid_next;
    logic [CNT_W-1:0]   probes_reg, probes_next;
    logic [IDX_W-1:0]   scan_reg, scan_next;
    logic               found_reg, found_next;
    logic [FIRST_W-1:0] first_reg, first_next;
    logic [PROBE_W-1:0] probe_reg, probe_next;
    logic               dropped_reg, dropped_next;

    value_t             rd_data_reg;
    logic [IDX_W-1:0]   rd_addr;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    value_t             mem_wdata;

    logic [CNT_W:0]     mid_sum;
    logic [IDX_W-1:0]   mid_w;
    cmp_t               cmp;
    logic               req_fire;

    sts_cmp u_cmp (
        .key    (key_reg),
        .entry  (rd_data_reg),
        .result (cmp)
    );

    // bounds kept as [lo, hi1) so no negative high bound is needed
    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi1_reg} - (CNT_W + 1)'(1);
    assign mid_w    = mid_sum[IDX_W:1];

    assign req.ready = (state_reg == S_IDLE) && (!ovalid_reg || rsp.ready);
    assign req_fire  = req.valid && req.ready;

    assign rsp.valid        = ovalid_reg;
    assign rsp.found        = found_reg;
    assign rsp.first_index  = first_reg;
    assign rsp.probe_count  = probe_reg;
    assign rsp.load_dropped = dropped_reg;

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        ovalid_next  = ovalid_reg && !rsp.ready;
        key_next     = key_reg;
        pos_next     = pos_reg;
        lo_next      = lo_reg;
        hi1_next     = hi1_reg;
        mid_next     = mid_reg;
        probes_next  = probes_reg;
        scan_next    = scan_reg;
        found_next   = found_reg;
        first_next   = first_reg;
        probe_next   = probe_reg;
        dropped_next = dropped_reg;
        rd_addr      = '0;
        mem_we       = 1'b0;
        mem_waddr    = pos_reg;
        mem_wdata    = key_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    key_next     = req.value;
                    found_next   = 1'b0;
                    first_next   = '0;
                    probe_next   = '0;
                    dropped_next = 1'b0;
                    priority if (req.operation == OP_LOAD)
                    begin
                        if (count_reg == FULL)
                        begin
                            dropped_next = 1'b1;
                            ovalid_next  = 1'b1;
                        end
                        else
                        begin
                            pos_next   = count_reg[IDX_W-1:0];
                            state_next = S_INS_RD;
                        end
                    end
                    else if (req.operation == OP_QUERY)
                    begin
                        lo_next     = '0;
                        hi1_next    = count_reg;
                        probes_next = '0;
                        state_next  = S_SRCH_RD;
                    end
                    else if (req.operation == OP_CLEAR)
                    begin
                        count_next  = '0;
                        ovalid_next = 1'b1;
                    end
                    else
                    begin
                        ovalid_next = 1'b1;
                    end
                end
            end
            S_INS_RD:
            begin
                if (pos_reg == '0)
                begin
                    mem_we      = 1'b1;
                    count_next  = count_reg + CNT_W'(1);
                    ovalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    rd_addr    = pos_reg - IDX_W'(1);
                    state_next = S_INS_CMP;
                end
            end
            S_INS_CMP:
            begin
                mem_we = 1'b1;
                if (cmp.key_lt)
                begin
                    // larger entry moves up one place
                    mem_wdata  = rd_data_reg;
                    pos_next   = pos_reg - IDX_W'(1);
                    state_next = S_INS_RD;
                end
                else
                begin
                    count_next  = count_reg + CNT_W'(1);
                    ovalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_SRCH_RD:
            begin
                if (lo_reg < hi1_reg)
                begin
                    rd_addr     = mid_w;
                    mid_next    = mid_w;
                    probes_next = probes_reg + CNT_W'(1);
                    state_next  = S_SRCH_CMP;
                end
                else
                begin
                    ovalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_SRCH_CMP:
            begin
                if (cmp.eq)
                begin
                    scan_next  = '0;
                    state_next = S_SCAN_RD;
                end
                else
                begin
                    if (cmp.key_lt)
                    begin
                        hi1_next = CNT_W'(mid_reg);
                    end
                    else
                    begin
                        lo_next = CNT_W'(mid_reg) + CNT_W'(1);
                    end
                    state_next = S_SRCH_RD;
                end
            end
            S_SCAN_RD:
            begin
                rd_addr    = scan_reg;
                state_next = S_SCAN_CMP;
            end
            S_SCAN_CMP:
            begin
                if (cmp.eq)
                begin
                    found_next  = 1'b1;
                    first_next  = FIRST_W'(scan_reg);
                    probe_next  = PROBE_W'(probes_reg);
                    ovalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    scan_next  = scan_reg + IDX_W'(1);
                    state_next = S_SCAN_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg     <= key_next;
        pos_reg     <= pos_next;
        lo_reg      <= lo_next;
        hi1_reg     <= hi1_next;
        mid_reg     <= mid_next;
        probes_reg  <= probes_next;
        scan_reg    <= scan_next;
        found_reg   <= found_next;
        first_reg   <= first_next;
        probe_reg   <= probe_next;
        dropped_reg <= dropped_next;
    end

    // table memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            table_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= table_mem[rd_addr];
    end

    `STS_ASSERT_NEVER(a_count_bound, clk, rst_n, count_reg > FULL)
    `STS_ASSERT(a_mid_in_range, clk, rst_n,
        (state_reg == S_SRCH_CMP) |-> (CNT_W'(mid_reg) >= lo_reg && CNT_W'(mid_reg) < hi1_reg))
    `STS_ASSERT(a_full_load_drops, clk, rst_n,
        (req_fire && req.operation == OP_LOAD && count_reg == FULL)
            |=> (rsp.valid && rsp.load_dropped))
    `STS_ASSERT(a_miss_fields_zero, clk, rst_n,
        (rsp.valid && !rsp.found) |-> (rsp.first_index == '0 && rsp.probe_count == '0))
    `STS_ASSERT(a_clear_empties, clk, rst_n,
        (req_fire && req.operation == OP_CLEAR) |=> (count_reg == '0 && rsp.valid))

endmodule

// ===== dv/tb_sorted_table_search_unit.sv =====
`timescale 1ns / 100ps

module tb_sorted_table_search_unit;

    import sts_pkg::*;

    localparam int TABLE_SIZE = 16;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 360;
    localparam int IDLE_PCT = 36;
    localparam int TAIL_CYCLES = 100;

    typedef struct packed {
        logic               found;
        logic [FIRST_W-1:0] first_index;
        logic [PROBE_W-1:0] probe_count;
        logic               load_dropped;
    } lookup_result_t;

    typedef struct {
        logic [OP_W-1:0] op;
        value_t          val;
        bit              typed;
        lookup_result_t  res;
    } stim_row_t;

    localparam lookup_result_t RES_NONE = '0;
    localparam lookup_result_t RES_DROPPED = '{
        found: 1'b0, first_index: '0, probe_count: '0, load_dropped: 1'b1
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    bit   calm = 1'b0;

    sts_in_if  req ();
    sts_out_if rsp ();

    sorted_table_search_unit #(
        .TABLE_SIZE (TABLE_SIZE)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    value_t         shadow_table [TABLE_SIZE];
    int unsigned    shadow_count;
    lookup_result_t pending_results [$];

    int unsigned mismatches;
    int unsigned counted_items;
    int unsigned n_loads, n_drops, n_queries, n_hits, n_clears, n_unused;

    // extremes, duplicates, deep shifts, full-table drop, miss, clear
    stim_row_t directed_rows [25] = '{
        '{OP_QUERY,  value_t'(0),      1'b1, RES_NONE},
        '{OP_UNUSED, value_t'(32767),  1'b1, RES_NONE},
        '{OP_LOAD,   value_t'(-32768), 1'b1, RES_NONE},
        '{OP_LOAD,   value_t'(32767),  1'b1, RES_NONE},
        '{OP_LOAD,   value_t'(0),      1'b0, RES_NONE},
        '{OP_LOAD,   value_t'(0),      1'b0, RES_NONE},
        '{OP_LOAD,   value_t'(-1),     1'b0, RES_NONE},
        '{OP_LOAD,   value_t'(100),    1'b0, RES_NONE},
        '{OP_LOAD,   value_t'(99),     1'b0, RES_NONE},
        '{OP_LOAD,   value_t'(98),     1'b0, RES_NONE},
        '{OP_LOAD,   value_t'(97),     1'b0, RES_NONE},
        '{OP_LOAD,   value_t'(96),     1'b0, RES_NONE},
        '{OP_LOAD,   value_t'(95),     1'b0, RES_NONE},
        '{OP_LOAD,   value_t'(94),     1'b0, RES_NONE},
        '{OP_LOAD,   value_t'(93),     1'b0, RES_NONE},
        '{OP_LOAD,   value_t'(92),     1'b0, RES_NONE},
        '{OP_LOAD,   value_t'(91),     1'b0, RES_NONE},
        '{OP_LOAD,   value_t'(90),     1'b0, RES_NONE},
        '{OP_LOAD,   value_t'(1),      1'b1, RES_DROPPED},
        '{OP_QUERY,  value_t'(-32768), 1'b0, RES_NONE},
        '{OP_QUERY,  value_t'(32767),  1'b0, RES_NONE},
        '{OP_QUERY,  value_t'(0),      1'b0, RES_NONE},
        '{OP_QUERY,  value_t'(5),      1'b1, RES_NONE},
        '{OP_CLEAR,  value_t'(-1),     1'b1, RES_NONE},
        '{OP_QUERY,  value_t'(0),      1'b1, RES_NONE}
    };

    always #2 clk = ~clk;

    function automatic lookup_result_t apply_item(input logic [OP_W-1:0] op, input value_t val);
        lookup_result_t r;
        int lo, hi, mid, pos, probes;
        r = '0;
        case (op)
            OP_LOAD:
            begin
                n_loads++;
                if (shadow_count >= TABLE_SIZE)
                begin
                    r.load_dropped = 1'b1;
                    n_drops++;
                end
                else
                begin
                    pos = shadow_count;
                    while (pos > 0 && shadow_table[pos-1] > val)
                    begin
                        shadow_table[pos] = shadow_table[pos-1];
                        pos--;
                    end
                    shadow_table[pos] = val;
                    shadow_count++;
                end
            end
            OP_QUERY:
            begin
                n_queries++;
                lo = 0;
                hi = int'(shadow_count) - 1;
                probes = 0;
                while (lo <= hi && !r.found)
                begin
                    mid = (lo + hi) / 2;
                    probes++;
                    if (shadow_table[mid] == val)
                    begin
                        r.found = 1'b1;
                        r.probe_count = probes[PROBE_W-1:0];
                    end
                    else if (val < shadow_table[mid])
                        hi = mid - 1;
                    else
                        lo = mid + 1;
                end
                if (r.found)
                begin
                    n_hits++;
                    pos = 0;
                    while (shadow_table[pos] != val)
                        pos++;
                    r.first_index = pos[FIRST_W-1:0];
                end
            end
            OP_CLEAR:
            begin
                n_clears++;
                shadow_count = 0;
            end
            default:
                n_unused++;
        endcase
        return r;
    endfunction

    function automatic value_t pick_value(input int mode);
        value_t v;
        case (mode)
            0: v = value_t'(int'($urandom_range(6)) - 3);
            1: v = value_t'($urandom);
            default:
            begin
                case ($urandom_range(5))
                    0: v = value_t'(-32768);
                    1: v = value_t'(32767);
                    2: v = value_t'(-32767);
                    3: v = value_t'(32766);
                    4: v = value_t'(0);
                    default: v = value_t'(-1);
                endcase
            end
        endcase
        return v;
    endfunction

    function automatic value_t pick_key(input int mode);
        value_t k;
        int sel;
        sel = $urandom_range(9);
        if (shadow_count > 0 && sel < 6)
            k = shadow_table[$urandom_range(shadow_count - 1)];
        else if (shadow_count > 0 && sel < 8)
            k = value_t'(shadow_table[$urandom_range(shadow_count - 1)]
                         + ($urandom_range(1) ? 1 : -1));
        else
            k = pick_value(mode);
        return k;
    endfunction

    task automatic send_item(
        input logic [OP_W-1:0] op,
        input value_t          val,
        input bit              typed = 1'b0,
        input lookup_result_t  res = RES_NONE
    );
        lookup_result_t predicted;
        @(negedge clk);
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            req.valid <= 1'b0;
            @(negedge clk);
        end
        req.valid <= 1'b1;
        req.operation <= op;
        req.value <= val;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        predicted = apply_item(op, val);
        pending_results.push_back(typed ? res : predicted);
        if (op != OP_UNUSED)
            counted_items++;
    endtask

    always @(negedge clk)
    begin
        rsp.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge clk)
    begin
        lookup_result_t got, want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            got = '{rsp.found, rsp.first_index, rsp.probe_count, rsp.load_dropped};
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected item: found=%0b first=%0d probes=%0d drop=%0b",
                             $realtime, got.found, got.first_index, got.probe_count,
                             got.load_dropped);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.found !== want.found || got.first_index !== want.first_index ||
                    got.probe_count !== want.probe_count ||
                    got.load_dropped !== want.load_dropped)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: mismatch found/first/probes/drop exp %0b/%0d/%0d/%0b %s",
                                 $realtime, want.found, want.first_index, want.probe_count,
                                 want.load_dropped,
                                 $sformatf("got %0b/%0d/%0d/%0b", got.found,
                                           got.first_index, got.probe_count,
                                           got.load_dropped));
                end
            end
        end
    end

    initial
    begin
        int mode, n, seq_kind;
        bit drained;
        logic [OP_W-1:0] noise_op;
        drained = 1'b0;
        req.valid = 1'b0;
        req.operation = OP_LOAD;
        req.value = '0;
        shadow_count = 0;
        repeat (9) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        for (int i = 0; i < $size(directed_rows); i++)
            send_item(directed_rows[i].op, directed_rows[i].val, directed_rows[i].typed,
                      directed_rows[i].res);

        while (counted_items < $size(directed_rows) + RANDOM_ITEMS)
        begin
            calm = (counted_items >= 120 && counted_items < 200);
            if (!drained && counted_items >= 240)
            begin
                drained = 1'b1;
                @(negedge clk) req.valid <= 1'b0;
                while (pending_results.size() != 0)
                    @(posedge clk);
            end
            seq_kind = $urandom_range(9);
            mode = $urandom_range(2);
            if (seq_kind < 7)
            begin
                if ($urandom_range(4) != 0)
                    send_item(OP_CLEAR, value_t'($urandom));
                n = $urandom_range(1, 18);
                repeat (n)
                    send_item(OP_LOAD, pick_value(mode));
                n = $urandom_range(2, 8);
                repeat (n)
                begin
                    if ($urandom_range(7) == 0)
                        send_item(OP_LOAD, pick_value(mode));
                    else
                        send_item(OP_QUERY, pick_key(mode));
                end
            end
            else
            begin
                n = $urandom_range(1, 6);
                repeat (n)
                begin
                    noise_op = OP_W'($urandom_range(3));
                    send_item(noise_op, value_t'($urandom));
                end
            end
        end
        calm = 1'b0;

        @(negedge clk) req.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d loads (%0d dropped on a full table), %0d queries (%0d hits),",
                 n_loads, n_drops, n_queries, n_hits);
        $display("%0d clears and %0d unused-code items; %0d mismatches",
                 n_clears, n_unused, mismatches);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("timeout with %0d results pending", pending_results.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule
